// ===== design/wcup_pkg.sv =====
package wcup_pkg;

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 16;
    localparam int COUNT_W  = 16;
    localparam int BASE_W   = 6;
    localparam int DIGIT_W  = 6;
    localparam int STATUS_W = 2;
    localparam int PROD_W   = VALUE_W + BASE_W;

    // Queue between classifier and executor
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Radix codes
    localparam logic [BASE_W-1:0] BASE_AUTO = BASE_W'(0);
    localparam logic [BASE_W-1:0] BASE_ONE  = BASE_W'(1);
    localparam logic [BASE_W-1:0] BASE_OCT  = BASE_W'(8);
    localparam logic [BASE_W-1:0] BASE_DEC  = BASE_W'(10);
    localparam logic [BASE_W-1:0] BASE_HEX  = BASE_W'(16);
    localparam logic [BASE_W-1:0] BASE_MAX  = BASE_W'(36);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL     = CHAR_W'(8'h00);
    localparam logic [CHAR_W-1:0] CH_ZERO    = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CH_ONE     = CHAR_W'(8'h31);
    localparam logic [CHAR_W-1:0] CH_NINE    = CHAR_W'(8'h39);
    localparam logic [CHAR_W-1:0] CH_UPPER_A = CHAR_W'(8'h41);
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = CHAR_W'(8'h5A);
    localparam logic [CHAR_W-1:0] CH_LOWER_A = CHAR_W'(8'h61);
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = CHAR_W'(8'h7A);
    localparam logic [CHAR_W-1:0] CH_UPPER_X = CHAR_W'(8'h58);
    localparam logic [CHAR_W-1:0] CH_LOWER_X = CHAR_W'(8'h78);

    // Letters start at digit value ten
    localparam logic [DIGIT_W-1:0] LETTER_OFFSET = DIGIT_W'(10);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_BAD_BASE = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_EMPTY    = STATUS_W'(2);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    // One classified character
    typedef struct packed {
        logic               start;
        logic               term;
        logic               digit_ok;
        logic [DIGIT_W-1:0] digit;
        logic               is_zero;
        logic               is_x;
        logic               is_dec19;
    } cls_t;

    // Queue handshake towards the executor
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== design/wcup_front.sv =====
module wcup_front (
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [wcup_pkg::CHAR_W-1:0] s_ch,
    input  logic                       s_start_req,
    input  wcup_pkg::q_status_t        q_status,
    output logic                       push,
    output wcup_pkg::cls_t             push_item
);

    logic is_dec;
    logic is_lower;
    logic is_upper;

    // Accept whenever the queue has room
    assign s_ready = !q_status.full;
    assign push    = s_valid && !q_status.full;

    // Classify the character
    always_comb begin
        is_dec   = (s_ch >= wcup_pkg::CH_ZERO) && (s_ch <= wcup_pkg::CH_NINE);
        is_lower = (s_ch >= wcup_pkg::CH_LOWER_A) && (s_ch <= wcup_pkg::CH_LOWER_Z);
        is_upper = (s_ch >= wcup_pkg::CH_UPPER_A) && (s_ch <= wcup_pkg::CH_UPPER_Z);

        push_item.start    = s_start_req;
        push_item.term     = (s_ch == wcup_pkg::CH_NUL);
        push_item.digit_ok = is_dec || is_lower || is_upper;
        push_item.is_zero  = (s_ch == wcup_pkg::CH_ZERO);
        push_item.is_x     = (s_ch == wcup_pkg::CH_LOWER_X) || (s_ch == wcup_pkg::CH_UPPER_X);
        push_item.is_dec19 = (s_ch >= wcup_pkg::CH_ONE) && (s_ch <= wcup_pkg::CH_NINE);

        if (is_lower) begin
            push_item.digit = wcup_pkg::DIGIT_W'(s_ch - wcup_pkg::CH_LOWER_A)
                            + wcup_pkg::LETTER_OFFSET;
        end else if (is_upper) begin
            push_item.digit = wcup_pkg::DIGIT_W'(s_ch - wcup_pkg::CH_UPPER_A)
                            + wcup_pkg::LETTER_OFFSET;
        end else begin
            push_item.digit = wcup_pkg::DIGIT_W'(s_ch - wcup_pkg::CH_ZERO);
        end
    end

endmodule

// ===== design/wcup_queue.sv =====
module wcup_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  wcup_pkg::cls_t      push_item,
    input  logic                pop,
    output wcup_pkg::cls_t      pop_item,
    output wcup_pkg::q_status_t q_status
);

    wcup_pkg::cls_t                    mem_reg [wcup_pkg::QUEUE_DEPTH];
    logic [wcup_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [wcup_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [wcup_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;

    assign q_status.full  = (cnt_reg == wcup_pkg::QCNT_W'(wcup_pkg::QUEUE_DEPTH));
    assign q_status.empty = (cnt_reg == '0);
    assign pop_item       = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == wcup_pkg::QPTR_W'(wcup_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == wcup_pkg::QPTR_W'(wcup_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the request
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/wcup_back.sv =====
module wcup_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [wcup_pkg::BASE_W-1:0]   number_base,
    input  wcup_pkg::q_status_t           q_status,
    input  wcup_pkg::cls_t                q_item,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wcup_pkg::VALUE_W-1:0]  m_value,
    output logic [wcup_pkg::COUNT_W-1:0]  m_consumed,
    output logic [wcup_pkg::STATUS_W-1:0] m_status,
    output logic                          m_overflowed
);

    wcup_pkg::phase_t                  phase_reg, phase_next;
    logic [wcup_pkg::VALUE_W-1:0]      acc_reg, acc_next;
    logic                              ovf_reg, ovf_next;
    logic [wcup_pkg::BASE_W-1:0]       base_reg, base_next;
    logic [wcup_pkg::COUNT_W-1:0]      cnt_reg, cnt_next;

    logic                              m_valid_reg, m_valid_next;
    logic [wcup_pkg::VALUE_W-1:0]      m_value_reg, m_value_next;
    logic [wcup_pkg::COUNT_W-1:0]      m_consumed_reg, m_consumed_next;
    logic [wcup_pkg::STATUS_W-1:0]     m_status_reg, m_status_next;
    logic                              m_overflowed_reg, m_overflowed_next;

    logic                              out_free;
    logic                              go;
    logic                              base_bad;
    logic                              s_bad, s_empty, s_zero, s_undet, s_feed;
    logic                              z_x, z_feed, d_feed, feed, stop, emit;
    logic [wcup_pkg::BASE_W-1:0]       feed_base;
    logic [wcup_pkg::VALUE_W-1:0]      feed_acc;
    logic                              feed_ovf;
    logic [wcup_pkg::COUNT_W-1:0]      feed_cnt;
    logic [wcup_pkg::PROD_W-1:0]       prod;

    assign out_free = !m_valid_reg || m_ready;
    assign go       = !q_status.empty && out_free;
    assign pop      = go;

    // Classify the request against the current phase
    always_comb begin
        base_bad = (number_base == wcup_pkg::BASE_ONE) || (number_base > wcup_pkg::BASE_MAX);
        s_bad    = q_item.start && base_bad;
        s_empty  = q_item.start && !base_bad && q_item.term;
        s_zero   = q_item.start && !base_bad && !q_item.term && q_item.is_zero
                && ((number_base == wcup_pkg::BASE_AUTO) || (number_base == wcup_pkg::BASE_HEX));
        s_undet  = q_item.start && !base_bad && !q_item.term && !s_zero
                && (number_base == wcup_pkg::BASE_AUTO) && !q_item.is_dec19;
        s_feed   = q_item.start && !base_bad && !q_item.term && !s_zero && !s_undet;
        z_x      = !q_item.start && (phase_reg == wcup_pkg::PH_ZERO) && q_item.is_x;
        z_feed   = !q_item.start && (phase_reg == wcup_pkg::PH_ZERO) && !q_item.is_x;
        d_feed   = !q_item.start && (phase_reg == wcup_pkg::PH_DIGITS);
        feed     = s_feed || z_feed || d_feed;

        if (s_feed) begin
            feed_base = (number_base == wcup_pkg::BASE_AUTO) ? wcup_pkg::BASE_DEC : number_base;
        end else if (z_feed) begin
            feed_base = (base_reg == wcup_pkg::BASE_AUTO) ? wcup_pkg::BASE_OCT : base_reg;
        end else begin
            feed_base = base_reg;
        end

        feed_acc = d_feed ? acc_reg : '0;
        feed_ovf = d_feed && ovf_reg;
        if (s_feed) begin
            feed_cnt = '0;
        end else if (z_feed) begin
            feed_cnt = wcup_pkg::COUNT_W'(1);
        end else begin
            feed_cnt = cnt_reg;
        end

        stop = feed && (!q_item.digit_ok || (q_item.digit >= feed_base));
        emit = s_bad || s_empty || s_undet || stop;
        prod = wcup_pkg::PROD_W'(feed_acc) * wcup_pkg::PROD_W'(feed_base)
             + wcup_pkg::PROD_W'(q_item.digit);
    end

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (go) begin
            if (s_bad || s_empty || s_undet || stop) begin
                phase_next = wcup_pkg::PH_IDLE;
            end else if (s_zero) begin
                phase_next = wcup_pkg::PH_ZERO;
            end else if (z_x || feed) begin
                phase_next = wcup_pkg::PH_DIGITS;
            end
        end
    end

    // Accumulate digits and build the result
    always_comb begin
        acc_next          = acc_reg;
        ovf_next          = ovf_reg;
        base_next         = base_reg;
        cnt_next          = cnt_reg;
        m_valid_next      = out_free ? 1'b0 : m_valid_reg;
        m_value_next      = m_value_reg;
        m_consumed_next   = m_consumed_reg;
        m_status_next     = m_status_reg;
        m_overflowed_next = m_overflowed_reg;

        if (go) begin
            if (q_item.start) begin
                acc_next  = '0;
                ovf_next  = 1'b0;
                cnt_next  = '0;
                base_next = number_base;
            end
            if (s_zero) begin
                cnt_next = wcup_pkg::COUNT_W'(1);
            end
            if (z_x) begin
                base_next = wcup_pkg::BASE_HEX;
                cnt_next  = wcup_pkg::COUNT_W'(2);
            end
            if (feed && !stop) begin
                base_next = feed_base;
                cnt_next  = (feed_cnt == wcup_pkg::COUNT_MAX) ? feed_cnt : feed_cnt + 1'b1;
                acc_next  = feed_acc;
                ovf_next  = feed_ovf;
                if (!feed_ovf) begin
                    if (prod[wcup_pkg::PROD_W-1:wcup_pkg::VALUE_W] != '0) begin
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = prod[wcup_pkg::VALUE_W-1:0];
                    end
                end
            end

            if (emit) begin
                m_valid_next = 1'b1;
                if (stop) begin
                    m_value_next      = feed_ovf ? {wcup_pkg::VALUE_W{1'b1}} : feed_acc;
                    m_consumed_next   = feed_cnt;
                    m_status_next     = wcup_pkg::ST_OK;
                    m_overflowed_next = feed_ovf;
                end else begin
                    m_value_next      = '0;
                    m_consumed_next   = '0;
                    m_status_next     = s_bad ? wcup_pkg::ST_BAD_BASE : wcup_pkg::ST_EMPTY;
                    m_overflowed_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= wcup_pkg::PH_IDLE;
            acc_reg     <= '0;
            ovf_reg     <= 1'b0;
            base_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            ovf_reg     <= ovf_next;
            base_reg    <= base_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge aclk) begin
        m_value_reg      <= m_value_next;
        m_consumed_reg   <= m_consumed_next;
        m_status_reg     <= m_status_next;
        m_overflowed_reg <= m_overflowed_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_consumed   = m_consumed_reg;
    assign m_status     = m_status_reg;
    assign m_overflowed = m_overflowed_reg;

endmodule

// ===== design/wide_char_to_unsigned_parser.sv =====
// Streaming wide-character to unsigned integer parser. One character is taken
// per cycle on the s_ channel while the queue has room; s_start_req marks the
// first character of a string. The first character that is not a digit of the
// radix (a zero terminator among them) ends the number and gives one result on
// the m_ channel (value saturating to all ones on overflow, characters consumed,
// status). A classifier decodes each character and pushes it into a four-entry
// queue; the executor pops one request per cycle while the output register is
// free and does a single multiply-accumulate by the radix, so sustained rate is
// one character per clock while results are accepted. The executor pauses only
// while a result is held unaccepted in the output register; the queue then fills
// to four characters before s_ready drops. The user must write cfg_number_base
// only while no string is in flight; the block itself does not enforce this.
module wide_char_to_unsigned_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wcup_pkg::BASE_W-1:0]   cfg_number_base,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wcup_pkg::CHAR_W-1:0]   s_ch,
    input  logic                          s_start_req,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wcup_pkg::VALUE_W-1:0]  m_value,
    output logic [wcup_pkg::COUNT_W-1:0]  m_consumed,
    output logic [wcup_pkg::STATUS_W-1:0] m_status,
    output logic                          m_overflowed
);

    logic [wcup_pkg::BASE_W-1:0] number_base_reg, number_base_next;
    wcup_pkg::q_status_t         q_status;
    wcup_pkg::cls_t              push_item;
    wcup_pkg::cls_t              pop_item;
    logic                        push;
    logic                        pop;

    // Radix register
    assign cfg_ready        = 1'b1;
    assign number_base_next = cfg_valid ? cfg_number_base : number_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_base_reg <= wcup_pkg::BASE_AUTO;
        end else begin
            number_base_reg <= number_base_next;
        end
    end

    wcup_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_ch        (s_ch),
        .s_start_req (s_start_req),
        .q_status    (q_status),
        .push        (push),
        .push_item   (push_item)
    );

    wcup_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    wcup_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .number_base  (number_base_reg),
        .q_status     (q_status),
        .q_item       (pop_item),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_consumed   (m_consumed),
        .m_status     (m_status),
        .m_overflowed (m_overflowed)
    );

endmodule
